// File: sv/okmq_pkg.sv
// Shared constants, codes and field widths of the owner-keyed mailbox queues.
`default_nettype none

package okmq_pkg;

  // Default sizes of the block.
  localparam int NUM_BOXES_DEF  = 8;
  localparam int DEPTH_DEF      = 64;
  localparam int EVENT_BITS_DEF = 64;

  // Fixed widths of the word fields.
  localparam int ACTION_W = 3;
  localparam int ID_W     = 16;
  localparam int DATA_W   = 64;
  localparam int STATUS_W = 2;

  // Action codes of an input word.
  typedef enum logic [ACTION_W-1:0] {
    ACT_CREATE      = 3'd0,
    ACT_CREATE_ROOT = 3'd1,
    ACT_DESTROY     = 3'd2,
    ACT_PUT         = 3'd3,
    ACT_GET         = 3'd4,
    ACT_GET_ROOT    = 3'd5
  } action_t;

  // Status codes of a result word.
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NO_SLOT  = 2'd2
  } status_t;

endpackage

`default_nettype wire

// File: sv/okmq_if.sv
// Channel interfaces: request words, result words and the root id register write.
`default_nettype none

interface okmq_req_if;
  logic                           valid;
  logic                           ready;
  logic [okmq_pkg::ACTION_W-1:0]  action;
  logic [okmq_pkg::ID_W-1:0]      requester_id;
  logic [okmq_pkg::ID_W-1:0]      dest_id;
  logic [okmq_pkg::DATA_W-1:0]    event_data;

  modport source (output valid, action, requester_id, dest_id, event_data, input ready);
  modport sink   (input valid, action, requester_id, dest_id, event_data, output ready);
endinterface

interface okmq_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [okmq_pkg::STATUS_W-1:0]  status;
  logic [okmq_pkg::DATA_W-1:0]    got_data;

  modport source (output valid, status, got_data, input ready);
  modport sink   (input valid, status, got_data, output ready);
endinterface

interface okmq_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [okmq_pkg::ID_W-1:0]  root_owner_id;

  modport source (output valid, root_owner_id, input ready);
  modport sink   (input valid, root_owner_id, output ready);
endinterface

`default_nettype wire

// File: sv/okmq_scan.sv
// Shared compare unit: looks at one mailbox per cycle and keeps the running match.
`default_nettype none

module okmq_scan #(
  parameter int NUM_BOXES = okmq_pkg::NUM_BOXES_DEF,
  parameter int DEPTH     = okmq_pkg::DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic step,
  input  wire logic [(NUM_BOXES > 1 ? $clog2(NUM_BOXES) : 1)-1:0] idx,
  input  wire logic [okmq_pkg::ID_W-1:0] key,
  input  wire logic [1 + okmq_pkg::ID_W + (NUM_BOXES > 1 ? $clog2(NUM_BOXES) : 1)
                     + 2 * $clog2(DEPTH) + 1 - 1:0] entry,
  output logic [1 + 3 * (NUM_BOXES > 1 ? $clog2(NUM_BOXES) : 1) + 2 * $clog2(DEPTH) + 1
                + 1 + $clog2(NUM_BOXES + 1) + 1 - 1:0] result
);

  localparam int IB = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;
  localparam int PB = $clog2(DEPTH);
  localparam int CW = $clog2(NUM_BOXES + 1);

  typedef struct packed {
    logic                     in_use;
    logic [okmq_pkg::ID_W-1:0] owner;
    logic [IB-1:0]            rank;
    logic [PB-1:0]            wr;
    logic [PB-1:0]            rd;
    logic                     full;
  } entry_t;

  typedef struct packed {
    logic          found;
    logic [IB-1:0] idx;
    logic [IB-1:0] rank;
    logic [PB-1:0] wr;
    logic [PB-1:0] rd;
    logic          full;
    logic          free_found;
    logic [IB-1:0] free_idx;
    logic [CW-1:0] live;
  } scan_t;

  entry_t e;
  scan_t  acc;
  logic   hit;
  logic   better;

  assign e      = entry;
  assign result = acc;

  // An owner match wins when nothing matched yet or its rank is lower.
  assign hit    = e.in_use && (e.owner == key);
  assign better = hit && (!acc.found || (e.rank < acc.rank));

  // Running match, first free slot and live count.
  always_ff @(posedge clk) begin
    if (rst || start) begin
      acc.found      <= 1'b0;
      acc.free_found <= 1'b0;
      acc.live       <= '0;
      acc.idx        <= '0;
      acc.rank       <= '0;
      acc.wr         <= '0;
      acc.rd         <= '0;
      acc.full       <= 1'b0;
      acc.free_idx   <= '0;
    end else if (step) begin
      if (better) begin
        acc.found <= 1'b1;
        acc.idx   <= idx;
        acc.rank  <= e.rank;
        acc.wr    <= e.wr;
        acc.rd    <= e.rd;
        acc.full  <= e.full;
      end
      if (!e.in_use && !acc.free_found) begin
        acc.free_found <= 1'b1;
        acc.free_idx   <= idx;
      end
      if (e.in_use) begin
        acc.live <= acc.live + CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/owner_keyed_mailbox_queues.sv
// Top level: sequencer, mailbox table and event memory of the owner-keyed mailbox queues.
//
//  channel | dir | handshake       | word
//  --------+-----+-----------------+--------------------------------------------
//  req     | in  | valid / ready   | action, requester_id, dest_id, event_data
//  rsp     | out | valid / ready   | status, got_data
//  cfg     | in  | valid / ready   | root_owner_id (ready whenever out of reset)
//
//  A request word passes through accept, a scan of every mailbox through the shared
//  compare unit, execute and result; a destroy that finds its mailbox adds a
//  rank close-up pass over the table before the result.
//  Synchronous active-high reset empties every mailbox and clears the root flag.
//  A result waits in the output register until taken; the next word may be
//  accepted meanwhile and its own result then holds until that register frees up.
`default_nettype none

module owner_keyed_mailbox_queues #(
  parameter int NUM_BOXES  = okmq_pkg::NUM_BOXES_DEF,
  parameter int DEPTH      = okmq_pkg::DEPTH_DEF,
  parameter int EVENT_BITS = okmq_pkg::EVENT_BITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  okmq_req_if.sink  req,
  okmq_rsp_if.source rsp,
  okmq_cfg_if.sink  cfg
);

  localparam int IB = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;
  localparam int PB = $clog2(DEPTH);
  localparam int CW = $clog2(NUM_BOXES + 1);
  localparam int MW = NUM_BOXES * DEPTH;
  localparam int AW = (MW > 1) ? $clog2(MW) : 1;

  typedef struct packed {
    logic                      in_use;
    logic [okmq_pkg::ID_W-1:0] owner;
    logic [IB-1:0]             rank;
    logic [PB-1:0]             wr;
    logic [PB-1:0]             rd;
    logic                      full;
  } entry_t;

  typedef struct packed {
    logic          found;
    logic [IB-1:0] idx;
    logic [IB-1:0] rank;
    logic [PB-1:0] wr;
    logic [PB-1:0] rd;
    logic          full;
    logic          free_found;
    logic [IB-1:0] free_idx;
    logic [CW-1:0] live;
  } scan_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_EXEC = 5'b00100,
    S_FIX  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;

  // Mailbox table.
  logic                      box_in_use  [NUM_BOXES];
  logic [okmq_pkg::ID_W-1:0] box_owner   [NUM_BOXES];
  logic [IB-1:0]             box_rank    [NUM_BOXES];
  logic [PB-1:0]             write_index [NUM_BOXES];
  logic [PB-1:0]             read_index  [NUM_BOXES];
  logic                      ring_full   [NUM_BOXES];
  logic                      root_made;
  logic [okmq_pkg::ID_W-1:0] root_id;

  // Event memory.
  logic [EVENT_BITS-1:0] event_store [MW];
  logic [EVENT_BITS-1:0] mem_q;

  // Latched request word.
  logic [okmq_pkg::ACTION_W-1:0] act;
  logic [okmq_pkg::ID_W-1:0]     req_q;
  logic [okmq_pkg::ID_W-1:0]     key;
  logic [EVENT_BITS-1:0]         data_q;

  // Result staging and output register.
  okmq_pkg::status_t              res_status;
  logic                           res_get;
  logic                           out_valid;
  logic [okmq_pkg::STATUS_W-1:0]  out_status;
  logic [okmq_pkg::DATA_W-1:0]    out_data;

  logic [IB-1:0] idx;
  logic          idx_last;
  logic          in_acc;
  logic          scan_start;
  entry_t        entry;
  scan_t         sc;

  logic          put_ok;
  logic          get_ok;
  logic          mem_we;
  logic          mem_re;
  logic [PB-1:0] ptr;
  logic [PB-1:0] wr_inc;
  logic [AW-1:0] addr;

  assign in_acc     = req.valid && req.ready;
  assign req.ready  = (state == S_IDLE) && !rst;
  assign cfg.ready  = !rst;
  assign scan_start = in_acc;
  assign idx_last   = (idx == IB'(NUM_BOXES - 1));

  assign rsp.valid    = out_valid;
  assign rsp.status   = out_status;
  assign rsp.got_data = out_data;

  // Table entry under the scan index.
  always_comb begin
    entry.in_use = box_in_use[idx];
    entry.owner  = box_owner[idx];
    entry.rank   = box_rank[idx];
    entry.wr     = write_index[idx];
    entry.rd     = read_index[idx];
    entry.full   = ring_full[idx];
  end

  okmq_scan #(
    .NUM_BOXES (NUM_BOXES),
    .DEPTH     (DEPTH)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .start  (scan_start),
    .step   (state == S_SCAN),
    .idx    (idx),
    .key    (key),
    .entry  (entry),
    .result (sc)
  );

  // Ring pointer arithmetic and memory address of the matched mailbox.
  always_comb begin
    put_ok = sc.found && !sc.full;
    get_ok = sc.found && (sc.full || (sc.wr != sc.rd));
    wr_inc = (sc.wr == PB'(DEPTH - 1)) ? '0 : sc.wr + PB'(1);
    ptr    = (okmq_pkg::action_t'(act) == okmq_pkg::ACT_PUT) ? sc.wr : sc.rd;
    addr   = AW'(sc.idx) * AW'(DEPTH) + AW'(ptr);
    mem_we = (state == S_EXEC) && (okmq_pkg::action_t'(act) == okmq_pkg::ACT_PUT) && put_ok;
    mem_re = (state == S_EXEC) && get_ok &&
             ((okmq_pkg::action_t'(act) == okmq_pkg::ACT_GET) ||
              (okmq_pkg::action_t'(act) == okmq_pkg::ACT_GET_ROOT));
  end

  // Event memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      event_store[addr] <= data_q;
    end
    if (mem_re) begin
      mem_q <= event_store[addr];
    end
  end

  // Root owner id register.
  always_ff @(posedge clk) begin
    if (rst) begin
      root_id <= '0;
    end else if (cfg.valid && cfg.ready) begin
      root_id <= cfg.root_owner_id;
    end
  end

  // Request word latch and lookup key.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act    <= req.action;
      req_q  <= req.requester_id;
      data_q <= req.event_data[EVENT_BITS-1:0];
      case (okmq_pkg::action_t'(req.action))
        okmq_pkg::ACT_PUT:      key <= req.dest_id;
        okmq_pkg::ACT_GET_ROOT: key <= root_id;
        default:                key <= req.requester_id;
      endcase
    end
  end

  // Sequencer, mailbox table updates and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      root_made  <= 1'b0;
      res_status <= okmq_pkg::ST_DONE;
      res_get    <= 1'b0;
      out_valid  <= 1'b0;
      out_status <= '0;
      out_data   <= '0;
      for (int i = 0; i < NUM_BOXES; i++) begin
        box_in_use[i]  <= 1'b0;
        box_owner[i]   <= '0;
        box_rank[i]    <= '0;
        write_index[i] <= '0;
        read_index[i]  <= '0;
        ring_full[i]   <= 1'b0;
      end
    end else begin
      // The result state reloads the output register itself when it is taken.
      if (rsp.valid && rsp.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            idx   <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          idx <= idx + IB'(1);
          if (idx_last) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_status <= okmq_pkg::ST_DONE;
          res_get    <= 1'b0;
          state      <= S_DONE;
          case (okmq_pkg::action_t'(act))
            okmq_pkg::ACT_CREATE, okmq_pkg::ACT_CREATE_ROOT: begin
              if (!sc.free_found) begin
                res_status <= okmq_pkg::ST_NO_SLOT;
              end else begin
                box_in_use[sc.free_idx]  <= 1'b1;
                box_rank[sc.free_idx]    <= IB'(sc.live);
                write_index[sc.free_idx] <= '0;
                read_index[sc.free_idx]  <= '0;
                ring_full[sc.free_idx]   <= 1'b0;
                if ((okmq_pkg::action_t'(act) == okmq_pkg::ACT_CREATE_ROOT) && !root_made) begin
                  box_owner[sc.free_idx] <= root_id;
                  root_made              <= 1'b1;
                end else begin
                  box_owner[sc.free_idx] <= req_q;
                end
              end
            end
            okmq_pkg::ACT_DESTROY: begin
              if (sc.found) begin
                box_in_use[sc.idx] <= 1'b0;
                box_rank[sc.idx]   <= '0;
                idx                <= '0;
                state              <= S_FIX;
              end
            end
            okmq_pkg::ACT_PUT: begin
              if (put_ok) begin
                write_index[sc.idx] <= wr_inc;
                ring_full[sc.idx]   <= (wr_inc == sc.rd);
              end
            end
            okmq_pkg::ACT_GET, okmq_pkg::ACT_GET_ROOT: begin
              if (get_ok) begin
                read_index[sc.idx] <= (sc.rd == PB'(DEPTH - 1)) ? '0 : sc.rd + PB'(1);
                ring_full[sc.idx]  <= 1'b0;
                res_get            <= 1'b1;
              end else begin
                res_status <= okmq_pkg::ST_EMPTY;
              end
            end
            default: begin
            end
          endcase
        end
        S_FIX: begin
          // Ranks above the freed mailbox close up by one.
          if (box_in_use[idx] && (box_rank[idx] > sc.rank)) begin
            box_rank[idx] <= box_rank[idx] - IB'(1);
          end
          idx <= idx + IB'(1);
          if (idx_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_data   <= res_get ? okmq_pkg::DATA_W'(mem_q) : '0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: tb/tb_owner_keyed_mailbox_queues.sv
// Self-checking testbench for the owner-keyed mailbox queues, with its own prediction of every result.
`timescale 1ns / 1ps

module tb_owner_keyed_mailbox_queues;
  import okmq_pkg::*;

  localparam int NB         = NUM_BOXES_DEF;
  localparam int RING_DEPTH = DEPTH_DEF;
  localparam int EV_BITS    = EVENT_BITS_DEF;
  localparam logic [DATA_W-1:0] EVENT_MASK = {DATA_W{1'b1}} >> (DATA_W - EV_BITS);
  localparam int RUN_LIMIT  = 800000;
  localparam int PHASES     = 6;
  localparam int RAND_WORDS = 145;
  localparam int POOL_SIZE  = 6;

  typedef struct {
    action_t           action;
    logic [ID_W-1:0]   requester_id;
    logic [ID_W-1:0]   dest_id;
    logic [DATA_W-1:0] event_data;
  } mail_req_t;

  typedef struct {
    status_t           status;
    logic [DATA_W-1:0] got_data;
  } mail_rsp_t;

  logic clk = 1'b0;
  logic rst;

  okmq_req_if req_ch ();
  okmq_rsp_if rsp_ch ();
  okmq_cfg_if cfg_ch ();

  owner_keyed_mailbox_queues dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the mailbox table, the event memory and the root register.
  bit                box_live    [NB];
  logic [ID_W-1:0]   box_owner_q [NB];
  int unsigned       box_order   [NB];
  int unsigned       wr_ptr      [NB];
  int unsigned       rd_ptr      [NB];
  bit                ring_full   [NB];
  logic [DATA_W-1:0] event_mem   [NB*RING_DEPTH];
  bit                root_taken;
  logic [ID_W-1:0]   root_id;

  // Words waiting to be sent, results still owed by the block, and run bookkeeping.
  mail_req_t   pend_words[$];
  mail_rsp_t   owed_results[$];
  mail_req_t   in_flight;
  logic [ID_W-1:0] id_pool [POOL_SIZE];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned fail_count;
  int unsigned cycle_count;

  // Lowest-ranked live mailbox of an owner, or -1 when there is none.
  function automatic int find_mailbox(logic [ID_W-1:0] who);
    int best;
    best = -1;
    for (int i = 0; i < NB; i++) begin
      if (box_live[i] && box_owner_q[i] == who &&
          (best < 0 || box_order[i] < box_order[best])) begin
        best = i;
      end
    end
    return best;
  endfunction

  // Apply one accepted word to the mirror and return the result it must produce.
  function automatic mail_rsp_t predict_mailbox(mail_req_t w);
    mail_rsp_t   r;
    int          slot;
    int unsigned live;
    int unsigned cut;
    r.status   = ST_DONE;
    r.got_data = '0;
    case (w.action)
      ACT_CREATE, ACT_CREATE_ROOT: begin
        slot = -1;
        live = 0;
        for (int i = NB - 1; i >= 0; i--) begin
          if (!box_live[i]) slot = i;
          else live++;
        end
        if (slot < 0) begin
          r.status = ST_NO_SLOT;
        end else begin
          box_order[slot] = live;
          box_live[slot]  = 1'b1;
          if (w.action == ACT_CREATE_ROOT && !root_taken) begin
            box_owner_q[slot] = root_id;
            root_taken        = 1'b1;
          end else begin
            box_owner_q[slot] = w.requester_id;
          end
          wr_ptr[slot]    = 0;
          rd_ptr[slot]    = 0;
          ring_full[slot] = 1'b0;
        end
      end
      ACT_DESTROY: begin
        slot = find_mailbox(w.requester_id);
        if (slot >= 0) begin
          cut             = box_order[slot];
          box_live[slot]  = 1'b0;
          box_order[slot] = 0;
          for (int i = 0; i < NB; i++) begin
            if (box_live[i] && box_order[i] > cut) box_order[i]--;
          end
        end
      end
      ACT_PUT: begin
        slot = find_mailbox(w.dest_id);
        if (slot >= 0 && !ring_full[slot]) begin
          event_mem[slot*RING_DEPTH + wr_ptr[slot]] = w.event_data & EVENT_MASK;
          wr_ptr[slot]    = (wr_ptr[slot] + 1) % RING_DEPTH;
          ring_full[slot] = (wr_ptr[slot] == rd_ptr[slot]);
        end
      end
      ACT_GET, ACT_GET_ROOT: begin
        slot = find_mailbox(w.action == ACT_GET_ROOT ? root_id : w.requester_id);
        if (slot >= 0 && (ring_full[slot] || wr_ptr[slot] != rd_ptr[slot])) begin
          r.got_data      = event_mem[slot*RING_DEPTH + rd_ptr[slot]] & EVENT_MASK;
          rd_ptr[slot]    = (rd_ptr[slot] + 1) % RING_DEPTH;
          ring_full[slot] = 1'b0;
        end else begin
          r.status = ST_EMPTY;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic mail_req_t make_word(action_t a, logic [ID_W-1:0] who,
                                          logic [ID_W-1:0] dest, logic [DATA_W-1:0] data);
    mail_req_t w;
    w.action       = a;
    w.requester_id = who;
    w.dest_id      = dest;
    w.event_data   = data;
    return w;
  endfunction

  // Owner ids mostly come from a small pool so that lookups hit; some are fully random.
  function automatic logic [ID_W-1:0] pick_owner();
    if ($urandom_range(9) == 0) return ID_W'($urandom_range(65535));
    return id_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  function automatic logic [DATA_W-1:0] rand_event();
    return {$urandom, $urandom};
  endfunction

  function automatic mail_req_t rand_word();
    int unsigned pick;
    action_t     a;
    pick = $urandom_range(99);
    if (pick < 14)      a = ACT_CREATE;
    else if (pick < 17) a = ACT_CREATE_ROOT;
    else if (pick < 27) a = ACT_DESTROY;
    else if (pick < 60) a = ACT_PUT;
    else if (pick < 88) a = ACT_GET;
    else                a = ACT_GET_ROOT;
    return make_word(a, pick_owner(), pick_owner(), rand_event());
  endfunction

  // Fill one mailbox past its depth so that puts get dropped, then read it past empty.
  task automatic queue_fill_drain(logic [ID_W-1:0] who, bit via_root);
    for (int k = 1; k < POOL_SIZE; k++) begin
      if (id_pool[k] != who) pend_words.push_back(make_word(ACT_DESTROY, id_pool[k], '0, '0));
    end
    pend_words.push_back(make_word(ACT_CREATE, who, pick_owner(), rand_event()));
    repeat (RING_DEPTH + 2)
      pend_words.push_back(make_word(ACT_PUT, pick_owner(), who, rand_event()));
    repeat (RING_DEPTH + 2)
      pend_words.push_back(make_word(via_root ? ACT_GET_ROOT : ACT_GET, who, pick_owner(),
                                     rand_event()));
  endtask

  // Settle at a falling edge until every word is sent and every result is back.
  task automatic wait_drained();
    do @(negedge clk);
    while (pend_words.size() != 0 || req_ch.valid || owed_results.size() != 0);
  endtask

  // Write the root owner id register while the block is idle.
  task automatic write_root_id(logic [ID_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.root_owner_id <= value;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    root_id = value;
    @(negedge clk);
  endtask

  // Request driver: a word stays valid until taken, and the mirror is updated on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (req_ch.valid) owed_results.push_back(predict_mailbox(in_flight));
      if (pend_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_flight = pend_words.pop_front();
        req_ch.valid        <= 1'b1;
        req_ch.action       <= in_flight.action;
        req_ch.requester_id <= in_flight.requester_id;
        req_ch.dest_id      <= in_flight.dest_id;
        req_ch.event_data   <= in_flight.event_data;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver stalls at random.
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result monitor: compare each taken word with the oldest owed result.
  always @(posedge clk) begin : result_check
    mail_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (owed_results.size() == 0) begin
        fail_count++;
        $error("unexpected result word: status %0d, got_data %h",
               rsp_ch.status, rsp_ch.got_data);
      end else begin
        want = owed_results.pop_front();
        if (rsp_ch.status !== want.status) begin
          fail_count++;
          $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
        end
        if (rsp_ch.got_data !== want.got_data) begin
          fail_count++;
          $error("got_data: expected %h, actual %h", want.got_data, rsp_ch.got_data);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Stimulus sequence: reset, directed words, then random phases with new root ids.
  initial begin
    logic [ID_W-1:0] root_value;
    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.action       = ACT_CREATE;
    req_ch.requester_id = '0;
    req_ch.dest_id      = '0;
    req_ch.event_data   = '0;
    rsp_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.root_owner_id = '0;
    fail_count          = 0;
    cycle_count         = 0;
    root_taken          = 1'b0;
    root_id             = '0;
    send_idle_pct       = 37;
    recv_idle_pct       = 63;
    for (int i = 0; i < NB; i++) begin
      box_live[i]    = 1'b0;
      box_owner_q[i] = '0;
      box_order[i]   = 0;
      wr_ptr[i]      = 0;
      rd_ptr[i]      = 0;
      ring_full[i]   = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part with the root id at its top value.
    write_root_id(16'hFFFF);
    pend_words.push_back(make_word(ACT_GET, 16'h0000, 16'h0000, '0));
    pend_words.push_back(make_word(ACT_GET_ROOT, 16'h0000, 16'h0000, '0));
    pend_words.push_back(make_word(ACT_PUT, 16'h0000, 16'h1234, 64'h0123_4567_89AB_CDEF));
    // The first root create takes the root id; later ones fall back to the requester.
    pend_words.push_back(make_word(ACT_CREATE_ROOT, 16'h0001, 16'h0000, '0));
    pend_words.push_back(make_word(ACT_CREATE_ROOT, 16'h0002, 16'h0000, '0));
    pend_words.push_back(make_word(ACT_CREATE, 16'h0000, 16'hFFFF, '1));
    pend_words.push_back(make_word(ACT_PUT, 16'hFFFF, 16'hFFFF, '1));
    pend_words.push_back(make_word(ACT_PUT, 16'h0000, 16'hFFFF, '0));
    pend_words.push_back(make_word(ACT_GET_ROOT, 16'h0000, 16'h0000, '0));
    pend_words.push_back(make_word(ACT_GET, 16'hFFFF, 16'h0000, '1));
    pend_words.push_back(make_word(ACT_GET, 16'hFFFF, 16'h0000, '0));
    // A duplicate owner: the earlier mailbox wins every lookup.
    pend_words.push_back(make_word(ACT_CREATE, 16'h0000, 16'h0000, '0));
    pend_words.push_back(make_word(ACT_PUT, 16'h0000, 16'h0000, 64'hA5A5_5A5A_A5A5_5A5A));
    pend_words.push_back(make_word(ACT_DESTROY, 16'h0000, 16'h0000, '0));
    pend_words.push_back(make_word(ACT_GET, 16'h0000, 16'h0000, '0));
    pend_words.push_back(make_word(ACT_DESTROY, 16'h7777, 16'h0000, '0));
    // Fill the table, then a create and a root create find no free slot.
    repeat (5) pend_words.push_back(make_word(ACT_CREATE, 16'h8000, 16'h0000, '0));
    pend_words.push_back(make_word(ACT_CREATE, 16'h1111, 16'h0000, '0));
    pend_words.push_back(make_word(ACT_CREATE_ROOT, 16'h2222, 16'h0000, '0));
    pend_words.push_back(make_word(ACT_DESTROY, 16'h0002, 16'h0000, '0));
    pend_words.push_back(make_word(ACT_CREATE, 16'h5555, 16'h0000, '0));
    wait_drained();

    // Random phases: each sets a new root id, with the idling pattern changing every two.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       root_value = 16'h0000;
        2:       root_value = 16'hFFFF;
        3:       root_value = 16'h0001;
        5:       root_value = 16'h8000;
        default: root_value = ID_W'($urandom_range(65535));
      endcase
      if (ph < 2) begin
        send_idle_pct = 37;
        recv_idle_pct = 63;
      end else if (ph < 4) begin
        send_idle_pct = 63;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_root_id(root_value);
      id_pool[0] = root_value;
      id_pool[1] = 16'h0000;
      id_pool[2] = 16'hFFFF;
      for (int k = 3; k < POOL_SIZE; k++) id_pool[k] = ID_W'($urandom_range(65535));
      if (ph == 1) queue_fill_drain(id_pool[3], 1'b0);
      if (ph == 4) queue_fill_drain(id_pool[0], 1'b1);
      repeat (RAND_WORDS) pend_words.push_back(rand_word());
      wait_drained();
    end

    // Let any stray result show up before the verdict.
    repeat (2*NB + 16) @(posedge clk);
    if (owed_results.size() != 0) begin
      fail_count++;
      $error("%0d results never arrived", owed_results.size());
    end
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/okmq_pkg.sv
sv/okmq_if.sv
sv/okmq_scan.sv
sv/owner_keyed_mailbox_queues.sv
tb/tb_owner_keyed_mailbox_queues.sv
